// ----- rtl/grapheme_cluster_boundary_assert.svh -----
// Assertion macros used by the grapheme cluster boundary top level.
`ifndef GRAPHEME_CLUSTER_BOUNDARY_ASSERT_SVH
`define GRAPHEME_CLUSTER_BOUNDARY_ASSERT_SVH

`ifndef SYNTHESIS

`define GCB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grapheme cluster boundary check failed");

`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grapheme cluster boundary check failed");

`else

`define GCB_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/gcb_pkg.sv -----
// Package with the break classes, state type and widths of the grapheme cluster boundary block.
`timescale 1ns / 1ps

package gcb_pkg;

    localparam int CLASS_W     = 4;
    localparam int OFFSET_W    = 16;
    localparam int OFFSET_BITS = 16;

    localparam int OFFSET_KEEP = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
    localparam logic [OFFSET_W-1:0] OFFSET_MASK =
        OFFSET_W'(((OFFSET_W+1)'(1) << OFFSET_KEEP) - (OFFSET_W+1)'(1));

    typedef enum logic [CLASS_W-1:0] {
        CLS_OTHER   = 4'd0,
        CLS_CONTROL = 4'd1,
        CLS_CR      = 4'd2,
        CLS_LF      = 4'd3,
        CLS_L       = 4'd4,
        CLS_V       = 4'd5,
        CLS_LV      = 4'd6,
        CLS_LVT     = 4'd7,
        CLS_T       = 4'd8,
        CLS_EXTEND  = 4'd9,
        CLS_ZWJ     = 4'd10,
        CLS_SPACING = 4'd11,
        CLS_PREPEND = 4'd12,
        CLS_PICT    = 4'd13,
        CLS_RI      = 4'd14
    } class_t;

    typedef struct packed {
        class_t prior_class;
        logic   regional_odd;
        logic   pictograph_run;
        logic   zwj_after_pictograph;
    } gcb_state_t;

    localparam gcb_state_t STATE_RESET = '{
        prior_class:          CLS_OTHER,
        regional_odd:         1'b0,
        pictograph_run:       1'b0,
        zwj_after_pictograph: 1'b0
    };

endpackage

// ----- rtl/grapheme_cluster_boundary.sv -----
// Top level of the grapheme cluster boundary block: input register, rules and result register.
// Usage:
// The input channel (in_valid, in_ready) carries one decoded scalar per transaction:
// its break class, its code-unit offset and a flag that marks the first scalar of a text.
// The output channel (out_valid, out_ready) returns one transaction per input transaction,
// in order, with cluster_start set where a grapheme cluster begins and the offset echoed.
// After acceptance the scalar is held in the input register, then the rules are evaluated
// and the result is captured in the output register, which drives out_valid.
// Throughput is one transaction per cycle while out_ready stays high; the limit is the
// combinational rule evaluation with the one-scalar context register it reads and updates.
// A scalar flagged as start of text clears the context and always starts a cluster.
// Reset empties both registers and sets the context to the Other class with all run
// flags clear; the first scalar after reset is judged against that context.
// When the receiver stalls, the result holds in the output register while one more
// transaction can wait in the input register; in_ready drops only when both are full.
`timescale 1ns / 1ps
`include "grapheme_cluster_boundary_assert.svh"

module grapheme_cluster_boundary (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gcb_pkg::CLASS_W-1:0]   break_class,
    input  logic [gcb_pkg::OFFSET_W-1:0]  unit_offset,
    input  logic                          text_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cluster_start,
    output logic [gcb_pkg::OFFSET_W-1:0]  start_offset
);
    import gcb_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [CLASS_W-1:0]  class_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                start_reg;

    gcb_state_t          state_reg;
    gcb_state_t          state_next;
    gcb_state_t          state_upd;
    logic                boundary;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                cluster_start_reg;
    logic [OFFSET_W-1:0] start_offset_reg;

    logic                in_take;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);
    assign state_next     = advance ? state_upd : state_reg;

    gcb_rules u_rules (
        .state       (state_reg),
        .break_class (class_reg),
        .text_start  (start_reg),
        .boundary    (boundary),
        .state_upd   (state_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            class_reg  <= break_class;
            offset_reg <= unit_offset;
            start_reg  <= text_start;
        end
        if (advance)
        begin
            cluster_start_reg <= boundary;
            start_offset_reg  <= offset_reg & OFFSET_MASK;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cluster_start = cluster_start_reg;
    assign start_offset  = start_offset_reg;

    `GCB_ASSERT_NEXT(a_start_forces_boundary, clk, rst_n, advance && start_reg, out_valid && cluster_start)
    `GCB_ASSERT_NEXT(a_crlf_joins, clk, rst_n, advance && !start_reg && (state_reg.prior_class == CLS_CR) && (class_reg == CLS_LF), !cluster_start)
    `GCB_ASSERT_NEXT(a_state_holds_when_idle, clk, rst_n, !advance, $stable(state_reg))
    `GCB_ASSERT_SAME(a_ready_when_output_free, clk, rst_n, !out_valid_reg, in_ready)

endmodule

// ----- rtl/gcb_rules.sv -----
// Boundary rules and state update for one scalar of the grapheme cluster boundary block.
`timescale 1ns / 1ps

module gcb_rules (
    input  gcb_pkg::gcb_state_t          state,
    input  logic [gcb_pkg::CLASS_W-1:0]  break_class,
    input  logic                         text_start,
    output logic                         boundary,
    output gcb_pkg::gcb_state_t          state_upd
);
    import gcb_pkg::*;

    class_t     cls;
    gcb_state_t cur;
    logic       p_ctl;
    logic       c_ctl;
    logic       joins;

    always_comb
    begin
        // The code with no meaning is handled as Other.
        if (break_class > CLS_RI)
        begin
            cls = CLS_OTHER;
        end
        else
        begin
            cls = class_t'(break_class);
        end

        cur = text_start ? STATE_RESET : state;

        p_ctl = (cur.prior_class == CLS_CONTROL) || (cur.prior_class == CLS_CR) ||
                (cur.prior_class == CLS_LF);
        c_ctl = (cls == CLS_CONTROL) || (cls == CLS_CR) || (cls == CLS_LF);

        if ((cur.prior_class == CLS_CR) && (cls == CLS_LF))
        begin
            joins = 1'b1;
        end
        else if (p_ctl || c_ctl)
        begin
            joins = 1'b0;
        end
        else if ((cur.prior_class == CLS_L) &&
                 ((cls == CLS_L) || (cls == CLS_V) || (cls == CLS_LV) || (cls == CLS_LVT)))
        begin
            joins = 1'b1;
        end
        else if (((cur.prior_class == CLS_LV) || (cur.prior_class == CLS_V)) &&
                 ((cls == CLS_V) || (cls == CLS_T)))
        begin
            joins = 1'b1;
        end
        else if (((cur.prior_class == CLS_LVT) || (cur.prior_class == CLS_T)) &&
                 (cls == CLS_T))
        begin
            joins = 1'b1;
        end
        else if ((cls == CLS_EXTEND) || (cls == CLS_ZWJ) || (cls == CLS_SPACING) ||
                 (cur.prior_class == CLS_PREPEND))
        begin
            joins = 1'b1;
        end
        else if ((cls == CLS_PICT) && (cur.prior_class == CLS_ZWJ) &&
                 cur.zwj_after_pictograph)
        begin
            joins = 1'b1;
        end
        else if ((cls == CLS_RI) && (cur.prior_class == CLS_RI) && cur.regional_odd)
        begin
            joins = 1'b1;
        end
        else
        begin
            joins = 1'b0;
        end

        boundary = text_start || !joins;

        state_upd.prior_class          = cls;
        state_upd.zwj_after_pictograph = (cls == CLS_ZWJ) && cur.pictograph_run;
        state_upd.pictograph_run       = (cls == CLS_EXTEND) ? cur.pictograph_run
                                                              : (cls == CLS_PICT);
        state_upd.regional_odd         = (cls == CLS_RI) ? !cur.regional_odd : 1'b0;
    end

endmodule
